// ===== rtl/core/obb_yaw_box_overlap_test_macros.svh =====
// Assertion helpers for the box overlap block
`ifndef OBB_YAW_BOX_OVERLAP_TEST_MACROS_SVH
`define OBB_YAW_BOX_OVERLAP_TEST_MACROS_SVH

// same-cycle implication, clocked on aclk, off during reset
`define OBBOV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OBBOV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/obbov_pkg.sv =====
package obbov_pkg;

    localparam int TRIG_DEPTH = 1024;
    localparam int IDX_W      = $clog2(TRIG_DEPTH + 1);
    localparam int TRIG_SHIFT = 15;

    localparam int CFG_W      = 20;
    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] CFG_HALF_LENGTH = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HALF_WIDTH  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HALF_HEIGHT = 2'd2;

    localparam logic [CFG_W-1:0] HALF_LENGTH_RST = 20'd1229;
    localparam logic [CFG_W-1:0] HALF_WIDTH_RST  = 20'd614;
    localparam logic [CFG_W-1:0] HALF_HEIGHT_RST = 20'd410;

    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
    localparam longint unsigned TAYLOR_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};

    typedef logic [15:0] sin_tab_t [0:TRIG_DEPTH];

    // quarter-wave sine in Q15, Taylor series in Q30, worked out at elaboration
    function automatic sin_tab_t build_sin_tab();
        sin_tab_t tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint sum;
        longint unsigned ii;
        for (int i = 0; i <= TRIG_DEPTH; i++) begin
            ii   = longint'(i);
            x    = (PI_HALF_Q30 * ii) / TRIG_DEPTH;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int k = 1; k <= 7; k++) begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[k-1];
                if (k % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) sum = 0;
            sum = (sum + 16384) >>> 15;
            if (sum > 32768) sum = 32768;
            tab[i] = sum[15:0];
        end
        return tab;
    endfunction

    localparam sin_tab_t SIN_TAB = build_sin_tab();

    function automatic logic signed [16:0] sin_lookup(logic [15:0] h);
        logic [1:0]       q;
        logic [13:0]      f;
        logic [31:0]      prod;
        logic [IDX_W-1:0] idx;
        logic [15:0]      v;
        q    = h[15:14];
        f    = h[13:0];
        prod = 32'(f) * 32'(TRIG_DEPTH);
        idx  = IDX_W'(prod >> 14);
        if (q[0]) idx = IDX_W'(TRIG_DEPTH) - idx;
        v = SIN_TAB[idx];
        return q[1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction

endpackage

// ===== rtl/core/obb_yaw_box_overlap_test.sv =====
// channel | ports                    | payload
// s_      | s_tvalid/s_tready/s_tdata| two poses (x, y, z, heading) per item
// m_      | m_tvalid/m_tready/m_tdata| overlap flag
// cfg_    | cfg_wr_en/addr/wr_data   | half_length, half_width, half_height
// Six register stages: sine lookup, trig and offset products, sums, extent
// products, radius sums, compare. One item per cycle while the output is not stalled.
// Every stage moves on one enable that is high when the output register is
// empty or being taken, so a stall freezes the whole pipe and nothing is lost.
// Reset (synchronous, aresetn low) clears the valid bits and loads the default extents.
module obb_yaw_box_overlap_test (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [obbov_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [obbov_pkg::CFG_W-1:0]       cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // first_x, first_y, first_z, first_heading,
    // second_x, second_y, second_z, second_heading
    input  logic [175:0]                      s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // overlap, then zero fill
    output logic [7:0]                        m_tdata
);

    logic [obbov_pkg::CFG_W-1:0] half_length_reg;
    logic [obbov_pkg::CFG_W-1:0] half_width_reg;
    logic [obbov_pkg::CFG_W-1:0] half_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_length_reg <= obbov_pkg::HALF_LENGTH_RST;
            half_width_reg  <= obbov_pkg::HALF_WIDTH_RST;
            half_height_reg <= obbov_pkg::HALF_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                obbov_pkg::CFG_HALF_LENGTH: half_length_reg <= cfg_wr_data;
                obbov_pkg::CFG_HALF_WIDTH:  half_width_reg  <= cfg_wr_data;
                obbov_pkg::CFG_HALF_HEIGHT: half_height_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    logic advance;
    logic [5:0] vld_reg;

    assign advance  = !vld_reg[5] || m_tready;
    assign s_tready = advance;
    assign m_tvalid = vld_reg[5];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (advance) begin
            vld_reg <= {vld_reg[4:0], s_tvalid};
        end
    end

    // input fields
    logic signed [23:0] ax, ay, az, bx, by, bz;
    logic [15:0] ha, hb;
    assign ax = s_tdata[23:0];
    assign ay = s_tdata[47:24];
    assign az = s_tdata[71:48];
    assign ha = s_tdata[87:72];
    assign bx = s_tdata[111:88];
    assign by = s_tdata[135:112];
    assign bz = s_tdata[159:136];
    assign hb = s_tdata[175:160];

    // stage 1: lookup, offsets, height test
    logic signed [16:0] ca_reg, sa_reg, cb_reg, sb_reg;
    logic signed [24:0] dx_reg, dy_reg;
    logic               hsep1_reg;
    logic signed [24:0] dz;
    logic [24:0]        dz_abs;

    assign dz     = 25'(bz) - 25'(az);
    assign dz_abs = dz[24] ? 25'(-dz) : 25'(dz);

    always_ff @(posedge aclk) begin
        if (advance) begin
            ca_reg    <= obbov_pkg::sin_lookup(ha + 16'h4000);
            sa_reg    <= obbov_pkg::sin_lookup(ha);
            cb_reg    <= obbov_pkg::sin_lookup(hb + 16'h4000);
            sb_reg    <= obbov_pkg::sin_lookup(hb);
            dx_reg    <= 25'(bx) - 25'(ax);
            dy_reg    <= 25'(by) - 25'(ay);
            hsep1_reg <= dz_abs > {4'd0, half_height_reg, 1'b0};
        end
    end

    // stage 2: products
    logic signed [33:0] tp_reg [8];
    logic signed [41:0] dp_reg [8];
    logic               hsep2_reg;

    always_ff @(posedge aclk) begin
        if (advance) begin
            tp_reg[0] <= ca_reg * ca_reg;
            tp_reg[1] <= sa_reg * sa_reg;
            tp_reg[2] <= cb_reg * cb_reg;
            tp_reg[3] <= sb_reg * sb_reg;
            tp_reg[4] <= ca_reg * cb_reg;
            tp_reg[5] <= sa_reg * sb_reg;
            tp_reg[6] <= ca_reg * sb_reg;
            tp_reg[7] <= sa_reg * cb_reg;
            dp_reg[0] <= dx_reg * ca_reg;
            dp_reg[1] <= dy_reg * sa_reg;
            dp_reg[2] <= dx_reg * sa_reg;
            dp_reg[3] <= dy_reg * ca_reg;
            dp_reg[4] <= dx_reg * cb_reg;
            dp_reg[5] <= dy_reg * sb_reg;
            dp_reg[6] <= dx_reg * sb_reg;
            dp_reg[7] <= dy_reg * cb_reg;
            hsep2_reg <= hsep1_reg;
        end
    end

    // stage 3: axis weights and centre distances, as magnitudes
    // P = ca.cb + sa.sb, Q = ca.sb - sa.cb; K = c^2 + s^2 per box
    logic signed [34:0] ka_s, kb_s, p_s, q_s;
    logic signed [42:0] d_s [4];
    logic [32:0] ka_reg, kb_reg, p_reg, q_reg;
    logic [42:0] d3_reg [4];
    logic        hsep3_reg;

    assign ka_s   = 35'(tp_reg[0]) + 35'(tp_reg[1]);
    assign kb_s   = 35'(tp_reg[2]) + 35'(tp_reg[3]);
    assign p_s    = 35'(tp_reg[4]) + 35'(tp_reg[5]);
    assign q_s    = 35'(tp_reg[6]) - 35'(tp_reg[7]);
    assign d_s[0] = 43'(dp_reg[0]) + 43'(dp_reg[1]);
    assign d_s[1] = 43'(dp_reg[3]) - 43'(dp_reg[2]);
    assign d_s[2] = 43'(dp_reg[4]) + 43'(dp_reg[5]);
    assign d_s[3] = 43'(dp_reg[7]) - 43'(dp_reg[6]);

    always_ff @(posedge aclk) begin
        if (advance) begin
            ka_reg <= 33'(ka_s);
            kb_reg <= 33'(kb_s);
            p_reg  <= p_s[34] ? 33'(-p_s) : 33'(p_s);
            q_reg  <= q_s[34] ? 33'(-q_s) : 33'(q_s);
            for (int i = 0; i < 4; i++) begin
                d3_reg[i] <= d_s[i][42] ? 43'(-d_s[i]) : 43'(d_s[i]);
            end
            hsep3_reg <= hsep2_reg;
        end
    end

    // stage 4: extent products
    logic [52:0] lka_reg, wka_reg, lkb_reg, wkb_reg, lp_reg, wp_reg, lq_reg, wq_reg;
    logic [42:0] d4_reg [4];
    logic        hsep4_reg;

    always_ff @(posedge aclk) begin
        if (advance) begin
            lka_reg   <= 53'(half_length_reg) * 53'(ka_reg);
            wka_reg   <= 53'(half_width_reg)  * 53'(ka_reg);
            lkb_reg   <= 53'(half_length_reg) * 53'(kb_reg);
            wkb_reg   <= 53'(half_width_reg)  * 53'(kb_reg);
            lp_reg    <= 53'(half_length_reg) * 53'(p_reg);
            wp_reg    <= 53'(half_width_reg)  * 53'(p_reg);
            lq_reg    <= 53'(half_length_reg) * 53'(q_reg);
            wq_reg    <= 53'(half_width_reg)  * 53'(q_reg);
            d4_reg    <= d3_reg;
            hsep4_reg <= hsep3_reg;
        end
    end

    // stage 5: summed half-spans of both boxes on each axis
    logic [54:0] r_reg [4];
    logic [42:0] d5_reg [4];
    logic        hsep5_reg;

    always_ff @(posedge aclk) begin
        if (advance) begin
            r_reg[0]  <= 55'(lka_reg) + 55'(lp_reg) + 55'(wq_reg);
            r_reg[1]  <= 55'(wka_reg) + 55'(lq_reg) + 55'(wp_reg);
            r_reg[2]  <= 55'(lp_reg) + 55'(wq_reg) + 55'(lkb_reg);
            r_reg[3]  <= 55'(lq_reg) + 55'(wp_reg) + 55'(wkb_reg);
            d5_reg    <= d4_reg;
            hsep5_reg <= hsep4_reg;
        end
    end

    // stage 6: touching counts as overlap
    logic [3:0] axis_ok;
    logic       overlap_reg;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            axis_ok[i] = {d5_reg[i], {obbov_pkg::TRIG_SHIFT{1'b0}}} <= 58'(r_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            overlap_reg <= !hsep5_reg && (&axis_ok);
        end
    end

    assign m_tdata = {7'd0, overlap_reg};

endmodule

// ===== rtl/core/obbov_checker.sv =====
`include "obb_yaw_box_overlap_test_macros.svh"

module obbov_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    `OBBOV_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed under stall")
    `OBBOV_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[7:1] == 7'd0, "pad bits not zero")
    `OBBOV_ASSERT_NOW(a_stall_back, m_tvalid && !m_tready, !s_tready, "input taken while pipe frozen")
    `OBBOV_ASSERT_NOW(a_ready_free, !m_tvalid, s_tready, "input refused with output empty")

endmodule

bind obb_yaw_box_overlap_test obbov_checker u_obbov_checker (.*);

// ===== tb/tb_obb_yaw_box_overlap_test.sv =====
`timescale 1ns / 100ps

module tb_obb_yaw_box_overlap_test;

    class overlap_scoreboard;
        longint sin_q15_tab [0:obbov_pkg::TRIG_DEPTH];
        longint hl, hw, hh;
        bit overlap_q[$];
        int mismatches;
        int n_in;

        function new();
            longint unsigned x, x2, term;
            longint sum;
            for (int i = 0; i <= obbov_pkg::TRIG_DEPTH; i++) begin
                x = (64'd1686629713 * i) / obbov_pkg::TRIG_DEPTH;
                x2 = (x * x) >> 30;
                term = x;
                sum = x;
                for (int k = 1; k <= 7; k++) begin
                    term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
                    if (k % 2) sum = sum - longint'(term);
                    else sum = sum + longint'(term);
                end
                if (sum < 0) sum = 0;
                sum = (sum + 16384) >>> 15;
                if (sum > 32768) sum = 32768;
                sin_q15_tab[i] = sum;
            end
            hl = obbov_pkg::HALF_LENGTH_RST;
            hw = obbov_pkg::HALF_WIDTH_RST;
            hh = obbov_pkg::HALF_HEIGHT_RST;
            mismatches = 0;
            n_in = 0;
        endfunction

        function longint sine_of(bit [15:0] h);
            longint idx;
            idx = (longint'(h[13:0]) * obbov_pkg::TRIG_DEPTH) >> 14;
            if (h[14]) idx = obbov_pkg::TRIG_DEPTH - idx;
            return h[15] ? -sin_q15_tab[idx] : sin_q15_tab[idx];
        endfunction

        function bit boxes_overlap(bit [175:0] d);
            longint px [2], py [2], c [2], s [2], ax [4], ay [4];
            longint cx [2][4], cy [2][4];
            longint dz, p, lo [2], hi [2];
            int sx [4], sy [4];
            bit [15:0] h;
            sx = '{1, 1, -1, -1};
            sy = '{1, -1, -1, 1};
            dz = longint'($signed(d[71:48])) - longint'($signed(d[159:136]));
            if (dz < 0) dz = -dz;
            if (dz > 2 * hh) return 1'b0;
            for (int b = 0; b < 2; b++) begin
                px[b] = $signed(d[88*b +: 24]);
                py[b] = $signed(d[88*b+24 +: 24]);
                h = d[88*b+72 +: 16];
                s[b] = sine_of(h);
                c[b] = sine_of(h + 16'h4000);
                ax[2*b] = c[b];
                ay[2*b] = s[b];
                ax[2*b+1] = -s[b];
                ay[2*b+1] = c[b];
                for (int i = 0; i < 4; i++) begin
                    cx[b][i] = px[b] * 32768 + c[b] * sx[i] * hl - s[b] * sy[i] * hw;
                    cy[b][i] = py[b] * 32768 + s[b] * sx[i] * hl + c[b] * sy[i] * hw;
                end
            end
            for (int a = 0; a < 4; a++) begin
                for (int b = 0; b < 2; b++) begin
                    for (int i = 0; i < 4; i++) begin
                        p = cx[b][i] * ax[a] + cy[b][i] * ay[a];
                        if (i == 0 || p < lo[b]) lo[b] = p;
                        if (i == 0 || p > hi[b]) hi[b] = p;
                    end
                end
                if (hi[0] < lo[1] || hi[1] < lo[0]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_pair(bit [175:0] d);
            overlap_q = {overlap_q, boxes_overlap(d)};
            n_in++;
        endfunction

        function void check_flag(bit [7:0] got);
            bit want;
            if (overlap_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item %h", got);
                return;
            end
            want = overlap_q.pop_front();
            if (got[0] !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("overlap mismatch: expected %0d got %0d", want, got[0]);
            end
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              cfg_wr_en;
    logic [obbov_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [obbov_pkg::CFG_W-1:0]  cfg_wr_data;
    logic              s_tvalid;
    logic              s_tready;
    logic [175:0]      s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [7:0]        m_tdata;

    overlap_scoreboard sb = new();
    int idle_cycles = 0;
    bit held_off;

    obb_yaw_box_overlap_test DUT (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // no idling on either side for a stretch of items
    function automatic bit calm();
        return sb.n_in >= 400 && sb.n_in < 480;
    endfunction

    function automatic bit [175:0] pose_pair(int x0, int y0, int z0, int h0,
                                             int x1, int y1, int z1, int h1);
        return {16'(h1), 24'(z1), 24'(y1), 24'(x1), 16'(h0), 24'(z0), 24'(y0), 24'(x0)};
    endfunction

    task automatic send_pair(bit [175:0] d);
        s_tvalid <= 1'b1;
        s_tdata <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (!calm() && $urandom_range(99) < 20) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    // write enable is left high; the caller drops it after the last write
    task automatic write_reg(logic [obbov_pkg::CFG_ADDR_W-1:0] idx, int unsigned v);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= obbov_pkg::CFG_W'(v);
        @(posedge aclk);
        case (idx)
            obbov_pkg::CFG_HALF_LENGTH: sb.hl = v;
            obbov_pkg::CFG_HALF_WIDTH:  sb.hw = v;
            default:                    sb.hh = v;
        endcase
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.overlap_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic set_extents(int unsigned l, int unsigned w, int unsigned z);
        drain();
        write_reg(obbov_pkg::CFG_HALF_LENGTH, l);
        write_reg(obbov_pkg::CFG_HALF_WIDTH, w);
        write_reg(obbov_pkg::CFG_HALF_HEIGHT, z);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_pairs(int n);
        int span, x0, y0, z0, dx, dy, dz;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 15) begin
                send_pair(176'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom}));
            end else begin
                span = (sb.hl + sb.hw + 1 > 1000000) ? 1000000 : int'(sb.hl + sb.hw + 1);
                x0 = int'($urandom_range(0, 4000000)) - 2000000;
                y0 = int'($urandom_range(0, 4000000)) - 2000000;
                z0 = int'($urandom_range(0, 4000000)) - 2000000;
                dx = int'($urandom_range(0, 4 * span)) - 2 * span;
                dy = int'($urandom_range(0, 4 * span)) - 2 * span;
                dz = (sb.hh > 1000000) ? 2000000 : 2 * int'(sb.hh);
                dz = dz + int'($urandom_range(0, 4)) - 2;
                if ($urandom_range(1)) dz = int'($urandom_range(0, dz + 2));
                if ($urandom_range(1)) dz = -dz;
                send_pair(pose_pair(x0, y0, z0, $urandom, x0 + dx, y0 + dy, z0 + dz,
                                    $urandom));
            end
        end
    endtask

    // result side: random stalls plus one long hold-off
    initial begin
        m_tready = 1'b0;
        held_off = 1'b0;
        forever begin
            @(posedge aclk);
            if (!held_off && sb.n_in >= 200) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
            end
            m_tready <= calm() || $urandom_range(99) >= 20;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_pair(s_tdata);
            if (m_tvalid && m_tready) sb.check_flag(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 5000) begin
                $display("tb_obb_yaw_box_overlap_test failed");
                $finish;
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset extents: coincident, far apart, touching ends, height edge
        send_pair(pose_pair(0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(pose_pair(0, 0, 0, 0, 2458, 0, 0, 0));
        send_pair(pose_pair(0, 0, 0, 0, 2459, 0, 0, 0));
        send_pair(pose_pair(0, 0, 0, 16'h4000, 0, 1228, 0, 16'h4000));
        send_pair(pose_pair(100, 0, 820, 0, 100, 0, 0, 16'h8000));
        send_pair(pose_pair(100, 0, 821, 0, 100, 0, 0, 16'hC000));
        send_pair(pose_pair(0, 0, -820, 16'hFFFF, 0, 0, 0, 16'h3FFF));
        send_pair(pose_pair(-8388608, -8388608, -8388608, 0,
                            8388607, 8388607, 8388607, 16'hFFFF));
        send_pair(pose_pair(8388607, 8388607, 8388607, 16'h2000,
                            8388607, 8388607, 8388607, 16'h6000));
        send_pair(pose_pair(-8388608, -8388608, 0, 16'hA000, -8388000, -8388608, 0, 16'hE000));
        send_pair(pose_pair(0, 0, 0, 16'h2000, 1800, 1800, 0, 16'h2000));
        send_pair(pose_pair(0, 0, 0, 16'h2000, 1800, 0, 0, 16'h0000));
        send_pair(pose_pair(0, 0, 0, 16'h000F, 0, 0, 0, 16'h0010));
        random_pairs(130);

        set_extents(1048575, 1048575, 1048575);
        send_pair(pose_pair(-8388608, -8388608, -8388608, 0,
                            8388607, 8388607, 8388607, 16'h4000));
        send_pair(pose_pair(0, 0, -1048575, 0, 0, 0, 1048575, 0));
        send_pair(pose_pair(0, 0, -1048576, 0, 0, 0, 1048575, 0));
        random_pairs(100);

        set_extents(0, 0, 0);
        send_pair(pose_pair(5, 5, 5, 16'h1234, 5, 5, 5, 16'hABCD));
        send_pair(pose_pair(5, 5, 5, 0, 6, 5, 5, 0));
        send_pair(pose_pair(5, 5, 5, 0, 5, 5, 6, 0));
        random_pairs(100);

        set_extents(4096, 0, 2048);
        send_pair(pose_pair(0, 0, 0, 0, 0, 0, 0, 16'h4000));
        send_pair(pose_pair(0, 0, 0, 0, 8192, 0, 0, 0));
        random_pairs(100);

        set_extents($urandom_range(0, 40000), $urandom_range(0, 40000),
                    $urandom_range(0, 40000));
        random_pairs(110);

        set_extents($urandom_range(0, 1048575), $urandom_range(0, 1048575),
                    $urandom_range(0, 1048575));
        random_pairs(100);

        drain();
        repeat (20) @(posedge aclk);
        if (sb.mismatches == 0 && sb.overlap_q.size() == 0) begin
            $display("tb_obb_yaw_box_overlap_test passed");
        end else begin
            $display("tb_obb_yaw_box_overlap_test failed");
        end
        $finish;
    end
endmodule
